// File: rtl/core/vsd_pkg.sv
// Package for the view-space depth unit: widths, fixed-point format, tag structs
// and the small saturation helpers shared by the core modules.
// No dependencies.
package vsd_pkg;

	// Data and fixed-point format.
	localparam int DW        = 32;
	localparam int NEAR_W    = 31;
	localparam int FRAC_BITS = 16;

	// Row sums: three shifted products plus an offset, kept exactly.
	localparam int ACC_W = 2 * DW + 2 - FRAC_BITS;
	// Divider operands: numerator is a magnitude shifted up by the fraction.
	localparam int NUM_W = ACC_W + FRAC_BITS;
	localparam int DEN_W = ACC_W;
	// Quotient and square root widths.
	localparam int QW    = 32;
	localparam int RAD_W = 2 * QW;

	// Configuration registers.
	localparam int CFG_W     = 64;
	localparam int NUM_CFG   = 8;
	localparam int CFG_IDX_W = $clog2(NUM_CFG);
	localparam logic [CFG_W-1:0] ROW3_COLS23_RST = 64'd65536;

	typedef logic signed [DW-1:0] coef_t;
	typedef coef_t [3:0][3:0] mat_t;

	// Sideband that travels with the divide-by-w pipeline.
	typedef struct packed {
		logic              func;
		logic [NEAR_W-1:0] near;
		logic              wzero;
		logic              nx;
		logic              ny;
		logic              nz;
	} wd_tag_t;

	// Sideband that travels with the perspective divider.
	typedef struct packed {
		logic signed [DW-1:0] vx;
		logic signed [DW-1:0] vy;
		logic signed [DW-1:0] vz;
		logic                 func;
		logic                 wzero;
		logic                 near_nz;
	} pd_tag_t;

	// Sideband that travels with the square root pipeline.
	typedef struct packed {
		pd_tag_t     pd;
		logic [DW:0] smag;
	} sq_tag_t;

	localparam int TAG_W = $bits(sq_tag_t);

	// Clamp a quotient magnitude to the signed range and apply the sign.
	function automatic logic [QW-1:0] sat_q(input logic neg, input logic ovf,
			input logic [QW-1:0] q);
		logic [QW-1:0] lim;
		logic [QW-1:0] qs;
		lim = neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
		qs  = (ovf || (q > lim)) ? lim : q;
		return neg ? (~qs + 1'b1) : qs;
	endfunction

	// Magnitude of a signed word; the most negative value maps to 2^(DW-1).
	function automatic logic [DW-1:0] mag32(input logic signed [DW-1:0] v);
		logic [DW-1:0] u;
		u = v;
		return v[DW-1] ? (~u + 1'b1) : u;
	endfunction

endpackage

// File: rtl/core/view_space_depth_unit.sv
// Top level of the view-space depth unit: configuration registers, transform,
// divide by w, ray length, perspective divide and output register.
// Depends on vsd_pkg, vsd_xform, vsd_div and vsd_sqrt.
//
//  channel  | signals                                   | transaction when
//  ---------+-------------------------------------------+---------------------------
//  input    | in_valid in_ready func pos_* near_dist    | in_valid && in_ready
//  output   | out_valid out_ready depth view_* div_fault| out_valid && out_ready
//  config   | cfg_we cfg_index cfg_data                 | cfg_we
//
// One point enters per cycle unless the output register stalls; the divide by w,
// the perspective divide and the square root each have 33 stages.
// Reset clears all valid bits and loads the identity-w matrix (M[3][3] = 1.0).
// When the output register holds a result that is not taken, the whole
// pipeline holds and in_ready falls; nothing is dropped or repeated.
module view_space_depth_unit import vsd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 func,
	input  logic signed [DW-1:0] pos_x,
	input  logic signed [DW-1:0] pos_y,
	input  logic signed [DW-1:0] pos_z,
	input  logic [NEAR_W-1:0]    near_dist,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [DW-1:0] depth,
	output logic signed [DW-1:0] view_x,
	output logic signed [DW-1:0] view_y,
	output logic signed [DW-1:0] view_z,
	output logic                 div_fault,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic                   adv;
	logic [CFG_W-1:0]       cfg_q [NUM_CFG];
	mat_t                   mat;

	logic                   xf_vld;
	logic [NUM_W-1:0]       xf_num_x, xf_num_y, xf_num_z;
	logic [DEN_W-1:0]       xf_den;
	wd_tag_t                xf_tag;

	logic                   wd_vld, ovf_x, ovf_y, ovf_z;
	logic [QW-1:0]          q_x, q_y, q_z;
	logic [TAG_W-1:0]       wd_tag_raw;
	wd_tag_t                wd;

	logic                   vld_s4, func_s4, wzero_s4;
	logic [NEAR_W-1:0]      near_s4;
	logic signed [DW-1:0]   vx_s4, vy_s4, vz_s4;

	logic                   vld_s5;
	logic [2*DW-1:0]        sqx_s5, sqy_s5, sqz_s5;
	logic signed [DW:0]     snear_s5;
	pd_tag_t                pd_s5;

	logic                   vld_s6;
	logic [RAD_W-1:0]       ssum_s6;
	sq_tag_t                sq_s6;

	logic                   sq_vld;
	logic [QW-1:0]          sq_root;
	logic [TAG_W-1:0]       sq_tag_raw;
	sq_tag_t                sq;

	logic                   vld_s7;
	logic [2*DW:0]          num_s7;
	logic [DW-1:0]          den_s7;
	pd_tag_t                pd_s7;

	logic                   pv_vld, p_ovf;
	logic [QW-1:0]          p_q;
	logic [TAG_W-1:0]       pv_tag_raw;
	pd_tag_t                pv;

	logic                   vld_s8, fault_s8;
	logic signed [DW-1:0]   depth_s8, vx_s8, vy_s8, vz_s8;
	logic signed [DW-1:0]   depth_c;
	logic                   fault_c;

	// The pipeline moves whenever the output register is empty or drained.
	assign adv      = !vld_s8 || out_ready;
	assign in_ready = adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				cfg_q[i] <= (i == NUM_CFG-1) ? ROW3_COLS23_RST : '0;
			end
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// Unpack two coefficients per register, high word first.
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			mat[r][0] = cfg_q[2*r][CFG_W-1:DW];
			mat[r][1] = cfg_q[2*r][DW-1:0];
			mat[r][2] = cfg_q[2*r+1][CFG_W-1:DW];
			mat[r][3] = cfg_q[2*r+1][DW-1:0];
		end
	end

	vsd_xform u_xform (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (in_valid && in_ready),
		.func    (func),
		.pos_x   (pos_x),
		.pos_y   (pos_y),
		.pos_z   (pos_z),
		.near    (near_dist),
		.mat     (mat),
		.out_vld (xf_vld),
		.num_x   (xf_num_x),
		.num_y   (xf_num_y),
		.num_z   (xf_num_z),
		.den     (xf_den),
		.tag     (xf_tag)
	);

	// Divide x, y and z by w in three parallel dividers.
	vsd_div u_div_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (xf_vld),
		.num     (xf_num_x),
		.den     (xf_den),
		.in_tag  (TAG_W'(xf_tag)),
		.out_vld (wd_vld),
		.quo     (q_x),
		.ovf     (ovf_x),
		.out_tag (wd_tag_raw)
	);

	vsd_div u_div_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (xf_vld),
		.num     (xf_num_y),
		.den     (xf_den),
		.in_tag  ('0),
		.out_vld (),
		.quo     (q_y),
		.ovf     (ovf_y),
		.out_tag ()
	);

	vsd_div u_div_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (xf_vld),
		.num     (xf_num_z),
		.den     (xf_den),
		.in_tag  ('0),
		.out_vld (),
		.quo     (q_z),
		.ovf     (ovf_z),
		.out_tag ()
	);

	assign wd = wd_tag_t'(wd_tag_raw[$bits(wd_tag_t)-1:0]);

	// Valid bits of the stages kept in this module.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= wd_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= sq_vld;
			vld_s8 <= pv_vld;
		end
	end

	// Stage 4: saturate the view coordinates; a zero w forces them to zero.
	always_ff @(posedge clk) begin
		if (adv) begin
			vx_s4     <= wd.wzero ? '0 : $signed(sat_q(wd.nx, ovf_x, q_x));
			vy_s4     <= wd.wzero ? '0 : $signed(sat_q(wd.ny, ovf_y, q_y));
			vz_s4     <= wd.wzero ? '0 : $signed(sat_q(wd.nz, ovf_z, q_z));
			func_s4   <= wd.func;
			near_s4   <= wd.near;
			wzero_s4  <= wd.wzero;
		end
	end

	// Stage 5: squares of the coordinates and view_z plus near.
	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s5        <= mag32(vx_s4) * mag32(vx_s4);
			sqy_s5        <= mag32(vy_s4) * mag32(vy_s4);
			sqz_s5        <= mag32(vz_s4) * mag32(vz_s4);
			snear_s5      <= {vz_s4[DW-1], vz_s4} + {2'b00, near_s4};
			pd_s5.vx      <= vx_s4;
			pd_s5.vy      <= vy_s4;
			pd_s5.vz      <= vz_s4;
			pd_s5.func    <= func_s4;
			pd_s5.wzero   <= wzero_s4;
			pd_s5.near_nz <= (near_s4 != '0);
		end
	end

	// Stage 6: squared length and |view_z + near|.
	always_ff @(posedge clk) begin
		if (adv) begin
			ssum_s6    <= sqx_s5 + sqy_s5 + sqz_s5;
			sq_s6.pd   <= pd_s5;
			sq_s6.smag <= snear_s5[DW] ? (~snear_s5 + 1'b1) : snear_s5;
		end
	end

	vsd_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s6),
		.rad     (ssum_s6),
		.in_tag  (TAG_W'(sq_s6)),
		.out_vld (sq_vld),
		.root    (sq_root),
		.out_tag (sq_tag_raw)
	);

	assign sq = sq_tag_t'(sq_tag_raw);

	// Stage 7: numerator |view_z + near| * |B| and divisor |view_z|.
	always_ff @(posedge clk) begin
		if (adv) begin
			num_s7 <= sq.smag * sq_root;
			den_s7 <= mag32(sq.pd.vz);
			pd_s7  <= sq.pd;
		end
	end

	vsd_div u_div_p (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s7),
		.num     (NUM_W'(num_s7)),
		.den     (DEN_W'(den_s7)),
		.in_tag  (TAG_W'(pd_s7)),
		.out_vld (pv_vld),
		.quo     (p_q),
		.ovf     (p_ovf),
		.out_tag (pv_tag_raw)
	);

	assign pv = pd_tag_t'(pv_tag_raw[$bits(pd_tag_t)-1:0]);

	// Depth selection by mode and the fault cases.
	always_comb begin
		depth_c = '0;
		fault_c = 1'b0;
		if (pv.wzero) begin
			fault_c = 1'b1;
		end else if (!pv.func) begin
			depth_c = $signed(sat_q(!pv.vz[DW-1] && (pv.vz != '0), 1'b0, mag32(pv.vz)));
		end else if (pv.vz == '0) begin
			fault_c = 1'b1;
		end else if (pv.near_nz) begin
			depth_c = $signed(sat_q(!pv.vz[DW-1], p_ovf, p_q));
		end
	end

	// Stage 8: output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			depth_s8 <= depth_c;
			vx_s8    <= pv.vx;
			vy_s8    <= pv.vy;
			vz_s8    <= pv.vz;
			fault_s8 <= fault_c;
		end
	end

	assign out_valid = vld_s8;
	assign depth     = depth_s8;
	assign view_x    = vx_s8;
	assign view_y    = vy_s8;
	assign view_z    = vz_s8;
	assign div_fault = fault_s8;

	// A faulted result never carries a depth.
	a_fault_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_fault |-> depth == '0)
		else $error("fault result with nonzero depth");

	// Faults come from a zero w, which clears x, y and z, or from a zero view_z, so a faulted result has view_z == 0.
	a_wzero_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_fault && (view_z != '0) |-> (view_x == '0) && (view_y == '0))
		else $error("zero-w fault with view coordinates set");

	// A held output freezes the inner pipeline.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(vld_s7) && $stable(vld_s6))
		else $error("pipeline moved during output stall");

endmodule

// File: rtl/core/vsd_xform.sv
// Matrix transform of the point by the 4x4 view matrix, three register stages.
// Gives divider operands (magnitudes and signs) for x, y and z over w.
// Depends on vsd_pkg.
module vsd_xform import vsd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_vld,
	input  logic                 func,
	input  logic signed [DW-1:0] pos_x,
	input  logic signed [DW-1:0] pos_y,
	input  logic signed [DW-1:0] pos_z,
	input  logic [NEAR_W-1:0]    near,
	input  mat_t                 mat,
	output logic                 out_vld,
	output logic [NUM_W-1:0]     num_x,
	output logic [NUM_W-1:0]     num_y,
	output logic [NUM_W-1:0]     num_z,
	output logic [DEN_W-1:0]     den,
	output wd_tag_t              tag
);

	logic signed [2*DW-1:0] prod_s1 [4][3];
	logic                   vld_s1, func_s1;
	logic [NEAR_W-1:0]      near_s1;

	logic signed [ACC_W-1:0] acc_c [4];
	logic signed [ACC_W-1:0] acc_s2 [4];
	logic                    vld_s2, func_s2;
	logic [NEAR_W-1:0]       near_s2;

	logic [ACC_W-1:0] mag_c [4];
	logic             vld_s3;
	logic [NUM_W-1:0] num_s3 [3];
	logic [DEN_W-1:0] den_s3;
	wd_tag_t          tag_s3;

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 1: twelve coefficient by coordinate products.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++) begin
				prod_s1[r][0] <= mat[r][0] * pos_x;
				prod_s1[r][1] <= mat[r][1] * pos_y;
				prod_s1[r][2] <= mat[r][2] * pos_z;
			end
			func_s1 <= func;
			near_s1 <= near;
		end
	end

	// Stage 2: floor-shift each product and add the translation column.
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			acc_c[r] = ACC_W'(prod_s1[r][0] >>> FRAC_BITS)
				+ ACC_W'(prod_s1[r][1] >>> FRAC_BITS)
				+ ACC_W'(prod_s1[r][2] >>> FRAC_BITS)
				+ ACC_W'(mat[r][3]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s2  <= acc_c;
			func_s2 <= func_s1;
			near_s2 <= near_s1;
		end
	end

	// Stage 3: magnitudes and quotient signs for the divide by w.
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			mag_c[r] = acc_s2[r][ACC_W-1] ? (~acc_s2[r] + 1'b1) : acc_s2[r];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				num_s3[r] <= {mag_c[r], {FRAC_BITS{1'b0}}};
			end
			den_s3       <= mag_c[3];
			tag_s3.func  <= func_s2;
			tag_s3.near  <= near_s2;
			tag_s3.wzero <= (acc_s2[3] == '0);
			tag_s3.nx    <= acc_s2[0][ACC_W-1] ^ acc_s2[3][ACC_W-1];
			tag_s3.ny    <= acc_s2[1][ACC_W-1] ^ acc_s2[3][ACC_W-1];
			tag_s3.nz    <= acc_s2[2][ACC_W-1] ^ acc_s2[3][ACC_W-1];
		end
	end

	assign out_vld = vld_s3;
	assign num_x   = num_s3[0];
	assign num_y   = num_s3[1];
	assign num_z   = num_s3[2];
	assign den     = den_s3;
	assign tag     = tag_s3;

endmodule

// File: rtl/core/vsd_div.sv
// Pipelined restoring divider: one quotient bit per stage, QW stages after an
// input stage that flags quotients too wide for QW bits. Depends on vsd_pkg.
module vsd_div import vsd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_vld,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_vld,
	output logic [QW-1:0]    quo,
	output logic             ovf,
	output logic [TAG_W-1:0] out_tag
);

	localparam int CW = DEN_W + QW;

	logic             vld_s [QW+1];
	logic [NUM_W-1:0] rem_s [QW+1];
	logic [DEN_W-1:0] den_s [QW+1];
	logic [QW-1:0]    q_s   [QW+1];
	logic             ovf_s [QW+1];
	logic [TAG_W-1:0] tag_s [QW+1];

	// Input stage: the quotient overflows when num >= den * 2^QW.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			q_s[0]   <= '0;
			ovf_s[0] <= (CW'(num) >= {den, {QW{1'b0}}});
			tag_s[0] <= in_tag;
		end
	end

	// One trial subtraction of the shifted divisor per stage, MSB first.
	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [CW-1:0] sh;
		logic [CW-1:0] diff;
		logic          ge;

		assign sh   = CW'(den_s[k]) << (QW - 1 - k);
		assign ge   = (CW'(rem_s[k]) >= sh);
		assign diff = CW'(rem_s[k]) - sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= ge ? NUM_W'(diff) : rem_s[k];
				den_s[k+1] <= den_s[k];
				q_s[k+1]   <= {q_s[k][QW-2:0], ge};
				ovf_s[k+1] <= ovf_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_vld = vld_s[QW];
	assign quo     = q_s[QW];
	assign ovf     = ovf_s[QW];
	assign out_tag = tag_s[QW];

endmodule

// File: rtl/core/vsd_sqrt.sv
// Pipelined integer square root, floor(sqrt(rad)), one root bit per stage after
// an input stage. Depends on vsd_pkg.
module vsd_sqrt import vsd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_vld,
	input  logic [RAD_W-1:0] rad,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_vld,
	output logic [QW-1:0]    root,
	output logic [TAG_W-1:0] out_tag
);

	logic             vld_s  [QW+1];
	logic [QW:0]      rem_s  [QW+1];
	logic [QW-1:0]    root_s [QW+1];
	logic [RAD_W-1:0] rad_s  [QW+1];
	logic [TAG_W-1:0] tag_s  [QW+1];

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			rad_s[0]  <= rad;
			tag_s[0]  <= in_tag;
		end
	end

	// Each stage brings down two radicand bits and tries root*4+1.
	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [QW+1:0] cand;
		logic [QW+1:0] trial;
		logic [QW+1:0] diff;
		logic          ge;

		assign cand  = {rem_s[k][QW-1:0], rad_s[k][RAD_W-1 -: 2]};
		assign trial = {root_s[k], 2'b01};
		assign ge    = (cand >= trial);
		assign diff  = cand - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1]  <= ge ? diff[QW:0] : cand[QW:0];
				root_s[k+1] <= {root_s[k][QW-2:0], ge};
				rad_s[k+1]  <= {rad_s[k][RAD_W-3:0], 2'b00};
				tag_s[k+1]  <= tag_s[k];
			end
		end
	end

	assign out_vld = vld_s[QW];
	assign root    = root_s[QW];
	assign out_tag = tag_s[QW];

endmodule
